// ----- rtl/core/ipc_pkg.sv -----
// ---------------------------------------------------------------------------
// ipc_pkg
// Types and codes shared by the address preclassifier modules.
// ---------------------------------------------------------------------------
package ipc_pkg;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [1:0] FAM_V4 = 2'd1;
    localparam logic [1:0] FAM_V6 = 2'd2;

    localparam logic [2:0] CLS_UNKNOWN   = 3'd0;
    localparam logic [2:0] CLS_ALLOCATED = 3'd1;
    localparam logic [2:0] CLS_RESERVED  = 3'd3;
    localparam logic [2:0] CLS_SPECIAL   = 3'd4;
    localparam logic [2:0] CLS_MAX       = 3'd5;

    localparam logic [2:0] RIR_UNKNOWN = 3'd0;
    localparam logic [2:0] RIR_NONE    = 3'd1;
    localparam logic [2:0] RIR_MAX     = 3'd6;

    localparam logic [2:0] GUESS_FIRST = 3'd1;
    localparam logic [2:0] GUESS_LAST  = 3'd5;

    localparam logic [1:0] CONF_LOW    = 2'd0;
    localparam logic [1:0] CONF_MEDIUM = 2'd1;
    localparam logic [1:0] CONF_HIGH   = 2'd2;

    localparam logic [3:0] RSN_TBL_UNKNOWN = 4'd10;

    localparam logic [4:0] RSN_V6_GLOBAL = 5'd4;
    localparam logic [4:0] RSN_V6_ULA    = 5'd5;
    localparam logic [4:0] RSN_V6_LINK   = 5'd6;
    localparam logic [4:0] RSN_V6_MCAST  = 5'd7;
    localparam logic [4:0] RSN_V4_BCAST  = 5'd11;
    localparam logic [4:0] RSN_V4_240    = 5'd12;
    localparam logic [4:0] RSN_V4_ZERO   = 5'd13;
    localparam logic [4:0] RSN_V4_P10    = 5'd14;
    localparam logic [4:0] RSN_V4_LOOP   = 5'd15;
    localparam logic [4:0] RSN_V4_LINK   = 5'd16;
    localparam logic [4:0] RSN_V4_P172   = 5'd17;
    localparam logic [4:0] RSN_V4_P192   = 5'd18;
    localparam logic [4:0] RSN_V4_MCAST  = 5'd19;
    localparam logic [4:0] RSN_V6_LOOP   = 5'd20;
    localparam logic [4:0] RSN_V6_DOC    = 5'd21;
    localparam logic [4:0] RSN_HINT      = 5'd22;
    localparam logic [4:0] RSN_NO_HINT   = 5'd23;

    localparam logic [7:0] V4_MAX_PLEN = 8'd32;
    localparam logic [7:0] V6_MAX_PLEN = 8'd128;
    localparam logic [7:0] HALF_PLEN   = 8'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  row_index;
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [2:0]  rir_guess;
        logic [1:0]  row_family;
        logic [7:0]  row_prefix_len;
        logic [2:0]  row_class;
        logic [2:0]  row_rir;
        logic [3:0]  row_reason;
        logic [1:0]  row_confidence;
    } in_word_t;

    typedef struct packed {
        logic       out_family;
        logic       table_hit;
        logic [2:0] out_class;
        logic [2:0] out_rir;
        logic [4:0] out_reason;
        logic [1:0] out_confidence;
    } out_word_t;

    typedef struct packed {
        logic [1:0] conf;
        logic [3:0] reason;
        logic [2:0] rir;
        logic [2:0] cls;
        logic [7:0] plen;
        logic [1:0] family;
    } row_attr_t;

    typedef struct packed {
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        row_attr_t   attr;
    } row_word_t;

    typedef struct packed {
        logic        is_v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [2:0]  rir_guess;
        logic        hit;
        row_attr_t   attr;
    } fix_req_t;

endpackage

// ----- rtl/core/ipc_ram.sv -----
// ---------------------------------------------------------------------------
// ipc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ipc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ipc_fixed.sv -----
// ---------------------------------------------------------------------------
// ipc_fixed
// Fixed special ranges, table verdict decode and registry fallback.
// ---------------------------------------------------------------------------
module ipc_fixed (
    input  ipc_pkg::fix_req_t  req,
    output ipc_pkg::out_word_t res
);

    logic [2:0]  guess_rir;
    logic [2:0]  cls;
    logic [2:0]  rir;
    logic [4:0]  reason;
    logic [1:0]  conf;
    logic        fixed_hit;
    logic [31:0] ip;
    logic [7:0]  v4_b0;
    logic [7:0]  v4_b1;
    logic [7:0]  v6_b0;
    logic [7:0]  v6_b1;

    assign ip    = req.addr_lo[31:0];
    assign v4_b0 = ip[31:24];
    assign v4_b1 = ip[23:16];
    assign v6_b0 = req.addr_hi[63:56];
    assign v6_b1 = req.addr_hi[55:48];

    always_comb
    begin
        if (req.rir_guess >= ipc_pkg::GUESS_FIRST && req.rir_guess <= ipc_pkg::GUESS_LAST)
        begin
            guess_rir = req.rir_guess + 3'd1;
        end
        else
        begin
            guess_rir = ipc_pkg::RIR_UNKNOWN;
        end

        if (req.hit)
        begin
            cls    = (req.attr.cls > ipc_pkg::CLS_MAX) ? ipc_pkg::CLS_UNKNOWN : req.attr.cls;
            rir    = (req.attr.rir > ipc_pkg::RIR_MAX) ? ipc_pkg::RIR_UNKNOWN : req.attr.rir;
            reason = (req.attr.reason > ipc_pkg::RSN_TBL_UNKNOWN)
                     ? {1'b0, ipc_pkg::RSN_TBL_UNKNOWN} : {1'b0, req.attr.reason};
            conf   = (req.attr.conf > ipc_pkg::CONF_HIGH) ? ipc_pkg::CONF_LOW : req.attr.conf;
        end
        else
        begin
            cls    = ipc_pkg::CLS_UNKNOWN;
            rir    = ipc_pkg::RIR_UNKNOWN;
            reason = ipc_pkg::RSN_NO_HINT;
            conf   = ipc_pkg::CONF_LOW;
        end

        fixed_hit = 1'b1;
        if (!req.is_v6)
        begin
            if (ip == 32'hFFFF_FFFF)
            begin
                reason = ipc_pkg::RSN_V4_BCAST;
            end
            else if (v4_b0 >= 8'd240)
            begin
                reason = ipc_pkg::RSN_V4_240;
            end
            else if (v4_b0 == 8'd0)
            begin
                reason = ipc_pkg::RSN_V4_ZERO;
            end
            else if (v4_b0 == 8'd10)
            begin
                reason = ipc_pkg::RSN_V4_P10;
            end
            else if (v4_b0 == 8'd127)
            begin
                reason = ipc_pkg::RSN_V4_LOOP;
            end
            else if (v4_b0 == 8'd169 && v4_b1 == 8'd254)
            begin
                reason = ipc_pkg::RSN_V4_LINK;
            end
            else if (v4_b0 == 8'd172 && v4_b1 >= 8'd16 && v4_b1 <= 8'd31)
            begin
                reason = ipc_pkg::RSN_V4_P172;
            end
            else if (v4_b0 == 8'd192 && v4_b1 == 8'd168)
            begin
                reason = ipc_pkg::RSN_V4_P192;
            end
            else if (v4_b0 >= 8'd224)
            begin
                reason = ipc_pkg::RSN_V4_MCAST;
            end
            else
            begin
                fixed_hit = 1'b0;
            end
            if (fixed_hit)
            begin
                cls  = (reason == ipc_pkg::RSN_V4_240) ? ipc_pkg::CLS_RESERVED
                                                       : ipc_pkg::CLS_SPECIAL;
                rir  = ipc_pkg::RIR_NONE;
                conf = ipc_pkg::CONF_HIGH;
            end
            else if (cls == ipc_pkg::CLS_UNKNOWN)
            begin
                if (guess_rir != ipc_pkg::RIR_UNKNOWN)
                begin
                    cls    = ipc_pkg::CLS_ALLOCATED;
                    rir    = guess_rir;
                    reason = ipc_pkg::RSN_HINT;
                    conf   = ipc_pkg::CONF_MEDIUM;
                end
                else
                begin
                    rir    = ipc_pkg::RIR_UNKNOWN;
                    reason = ipc_pkg::RSN_NO_HINT;
                    conf   = ipc_pkg::CONF_LOW;
                end
            end
        end
        else
        begin
            if (req.addr_hi == 64'd0 && req.addr_lo == 64'd1)
            begin
                reason = ipc_pkg::RSN_V6_LOOP;
            end
            else if ((v6_b0 & 8'hFE) == 8'hFC)
            begin
                reason = ipc_pkg::RSN_V6_ULA;
            end
            else if (v6_b0 == 8'hFE && (v6_b1 & 8'hC0) == 8'h80)
            begin
                reason = ipc_pkg::RSN_V6_LINK;
            end
            else if (v6_b0 == 8'hFF)
            begin
                reason = ipc_pkg::RSN_V6_MCAST;
            end
            else if (req.addr_hi[63:32] == 32'h2001_0db8)
            begin
                reason = ipc_pkg::RSN_V6_DOC;
            end
            else
            begin
                fixed_hit = 1'b0;
            end
            if (fixed_hit)
            begin
                cls  = ipc_pkg::CLS_SPECIAL;
                rir  = ipc_pkg::RIR_NONE;
                conf = ipc_pkg::CONF_HIGH;
            end
            else if ((v6_b0 & 8'hE0) == 8'h20)
            begin
                cls    = ipc_pkg::CLS_ALLOCATED;
                reason = ipc_pkg::RSN_V6_GLOBAL;
                rir    = guess_rir;
                conf   = (guess_rir != ipc_pkg::RIR_UNKNOWN) ? ipc_pkg::CONF_MEDIUM
                                                             : ipc_pkg::CONF_LOW;
            end
            else if (cls == ipc_pkg::CLS_UNKNOWN)
            begin
                rir    = ipc_pkg::RIR_UNKNOWN;
                reason = ipc_pkg::RSN_NO_HINT;
                conf   = ipc_pkg::CONF_LOW;
            end
        end

        res.out_family     = req.is_v6;
        res.table_hit      = req.hit;
        res.out_class      = cls;
        res.out_rir        = rir;
        res.out_reason     = reason;
        res.out_confidence = conf;
    end

endmodule

// ----- rtl/core/ip_address_preclassifier.sv -----
// ---------------------------------------------------------------------------
// ip_address_preclassifier
// IPv4/IPv6 address classifier with a loadable first-match prefix table.
// ---------------------------------------------------------------------------
// channel   direction  handshake                  payload
// item      in         item_valid / item_ready    item   (ipc_pkg::in_word_t)
// result    out        result_valid / result_ready result (ipc_pkg::out_word_t)
// cfg       in         cfg_valid / cfg_ready      cfg_data (table_rows, 7 bits)
//
// A write command raises result_valid from ST_FINISH once the result register
// is free. A classify reads table rows in ST_SCAN, one per cycle (at most
// min(table_rows, TABLE_DEPTH)), until the scan stops on a row or runs out,
// then registers its result from ST_FINISH. item_ready returns as the result
// appears, so no new item is taken before the last one is through. Reset clears
// control state only; the table is undefined until written. A stalled result
// holds in its register while the next item is taken; completion then waits
// for the register.
// ---------------------------------------------------------------------------
module ip_address_preclassifier #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ipc_pkg::in_word_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output ipc_pkg::out_word_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $bits(ipc_pkg::row_word_t);

    ipc_pkg::state_t    state_reg;
    ipc_pkg::state_t    state_next;
    logic [6:0]         table_rows_reg;
    logic [CW-1:0]      limit_reg;
    logic [CW-1:0]      limit_next;
    logic [CW-1:0]      rd_cnt_reg;
    logic [CW-1:0]      rd_cnt_next;
    logic               pend_reg;
    logic               pend_next;
    logic               hit_reg;
    logic               hit_next;
    ipc_pkg::row_attr_t attr_reg;
    ipc_pkg::row_attr_t attr_next;
    ipc_pkg::in_word_t  item_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    ipc_pkg::out_word_t result_reg;
    ipc_pkg::out_word_t result_next;

    logic               accept;
    logic [12:0]        idx_wide;
    logic [12:0]        rows_wide;
    logic [12:0]        depth_wide;
    logic [12:0]        lim_wide;
    logic               wr_en;
    logic               rd_en;
    logic               row_match;
    logic               v4_stop;
    logic               scan_stop;
    logic               scan_miss;
    logic               out_free;
    logic [RW-1:0]      ram_rdata;
    ipc_pkg::row_word_t row_rd;
    ipc_pkg::row_word_t row_wr;
    logic [31:0]        mask_v4;
    logic [63:0]        mask_hi;
    logic [63:0]        mask_lo;
    ipc_pkg::fix_req_t  fix_req;
    ipc_pkg::out_word_t fix_res;

    assign item_ready   = (state_reg == ipc_pkg::ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    assign idx_wide   = {7'd0, item.row_index};
    assign rows_wide  = {6'd0, table_rows_reg};
    assign depth_wide = 13'(TABLE_DEPTH);
    assign lim_wide   = (rows_wide > depth_wide) ? depth_wide : rows_wide;
    assign wr_en      = accept && (item.cmd == ipc_pkg::CMD_WRITE) && (idx_wide < depth_wide);

    assign row_wr.prefix_hi   = item.addr_hi;
    assign row_wr.prefix_lo   = item.addr_lo;
    assign row_wr.attr.family = item.row_family;
    assign row_wr.attr.plen   = item.row_prefix_len;
    assign row_wr.attr.cls    = item.row_class;
    assign row_wr.attr.rir    = item.row_rir;
    assign row_wr.attr.reason = item.row_reason;
    assign row_wr.attr.conf   = item.row_confidence;

    assign row_rd = ipc_pkg::row_word_t'(ram_rdata);

    ipc_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_wide[AW-1:0]),
        .wdata (row_wr),
        .re    (rd_en),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        mask_v4 = ~(32'hFFFF_FFFF >> row_rd.attr.plen);
        mask_hi = (row_rd.attr.plen >= ipc_pkg::HALF_PLEN)
                  ? 64'hFFFF_FFFF_FFFF_FFFF
                  : ~(64'hFFFF_FFFF_FFFF_FFFF >> row_rd.attr.plen);
        mask_lo = (row_rd.attr.plen <= ipc_pkg::HALF_PLEN)
                  ? 64'd0
                  : ~(64'hFFFF_FFFF_FFFF_FFFF >> (row_rd.attr.plen - ipc_pkg::HALF_PLEN));
        if (!item_reg.is_v6)
        begin
            v4_stop   = (row_rd.attr.family == ipc_pkg::FAM_V6);
            row_match = (row_rd.attr.family == ipc_pkg::FAM_V4)
                        && (row_rd.attr.plen <= ipc_pkg::V4_MAX_PLEN)
                        && (((item_reg.addr_lo[31:0] ^ row_rd.prefix_lo[31:0]) & mask_v4)
                            == 32'd0);
        end
        else
        begin
            v4_stop   = 1'b0;
            row_match = (row_rd.attr.family == ipc_pkg::FAM_V6)
                        && (row_rd.attr.plen <= ipc_pkg::V6_MAX_PLEN)
                        && (((item_reg.addr_hi ^ row_rd.prefix_hi) & mask_hi) == 64'd0)
                        && (((item_reg.addr_lo ^ row_rd.prefix_lo) & mask_lo) == 64'd0);
        end
    end

    assign scan_stop = pend_reg && (row_match || v4_stop);
    assign rd_en     = (state_reg == ipc_pkg::ST_SCAN) && (rd_cnt_reg < limit_reg) && !scan_stop;
    assign scan_miss = !pend_reg && !rd_en;

    assign fix_req.is_v6     = item_reg.is_v6;
    assign fix_req.addr_hi   = item_reg.addr_hi;
    assign fix_req.addr_lo   = item_reg.addr_lo;
    assign fix_req.rir_guess = item_reg.rir_guess;
    assign fix_req.hit       = hit_reg;
    assign fix_req.attr      = attr_reg;

    ipc_fixed u_fixed (
        .req (fix_req),
        .res (fix_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.cmd == ipc_pkg::CMD_CLASSIFY) ? ipc_pkg::ST_SCAN
                                                                     : ipc_pkg::ST_FINISH;
                end
            end
            ipc_pkg::ST_SCAN:
            begin
                if (scan_stop || scan_miss)
                begin
                    state_next = ipc_pkg::ST_FINISH;
                end
            end
            ipc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ipc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        limit_next        = limit_reg;
        rd_cnt_next       = rd_cnt_reg;
        pend_next         = 1'b0;
        hit_next          = hit_reg;
        attr_next         = attr_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            ipc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    limit_next  = lim_wide[CW-1:0];
                    rd_cnt_next = '0;
                    hit_next    = 1'b0;
                end
            end
            ipc_pkg::ST_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (scan_stop)
                begin
                    hit_next  = row_match;
                    attr_next = row_rd.attr;
                end
            end
            ipc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = (item_reg.cmd == ipc_pkg::CMD_CLASSIFY) ? fix_res : '0;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ipc_pkg::ST_IDLE;
            table_rows_reg   <= 7'd0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                table_rows_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg  <= limit_next;
        rd_cnt_reg <= rd_cnt_next;
        hit_reg    <= hit_next;
        attr_reg   <= attr_next;
        result_reg <= result_next;
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule
